>>> design/four_motor_speed_compensator_core_macros.svh
// Assertion macros used by the four-motor speed compensator checker.
`ifndef FOUR_MOTOR_SPEED_COMPENSATOR_CORE_MACROS_SVH
`define FOUR_MOTOR_SPEED_COMPENSATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FMSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmsc check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FMSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmsc check failed");

`endif

>>> design/fmsc_pkg.sv
// Types and constants of the four-motor speed compensator.
package fmsc_pkg;

  localparam int NMOT      = 4;
  localparam int MOT_W     = 2;
  localparam int SPEED_W   = 24;
  localparam int COEF_W    = 24;
  localparam int GAIN_W    = 48;
  localparam int DRIVE_W   = 32;
  localparam int ACC_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Register map: setpoints first, then the gain words.
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE     = 3'd4;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_m1;
    logic signed [SPEED_W-1:0] speed_m2;
    logic signed [SPEED_W-1:0] speed_m3;
    logic signed [SPEED_W-1:0] speed_m4;
  } in_beat_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_m1;
    logic signed [DRIVE_W-1:0] drive_m2;
    logic signed [DRIVE_W-1:0] drive_m3;
    logic signed [DRIVE_W-1:0] drive_m4;
  } out_beat_t;

endpackage

>>> design/four_motor_speed_compensator_core.sv
// Four-motor pole-placement speed compensator built around one shared multiplier.
//
// Usage: each input beat on in_data carries four measured speeds (signed Q16.8)
// for one control tick. The block forms err = setpoint - speed per motor and
// drive = 1.5*drive_prev - 0.5*drive_prev2 + K*err_prev - z0*K*err_prev2,
// rounded and saturated to 32 bits, and returns one output beat with the four
// drives. Setpoints and gain words are written through cfg_we/cfg_index/
// cfg_wdata; indexes 0..3 are setpoints, 4..7 gain words. The user must write
// them only while the block is idle; the block itself does not enforce this.
// Sequencing: one multiplier is shared by all motors and each motor passes
// through four steps (z0*K, K*err_prev, zk*err_prev2, final sum and saturate).
// in_ready is high only in the idle state and low while a beat is in work, so
// a new beat is not taken before the last one is through. A finished result
// sits in the output register; the next beat may be accepted meanwhile, and
// its last motor waits until the receiver takes the earlier result. Synchronous
// reset clears the setpoints, gain words, histories, sequencer and output valid
// flag. Motors beyond MOTOR_COUNT report a drive of zero.
module four_motor_speed_compensator_core #(
  parameter int MOTOR_COUNT    = 4,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fmsc_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fmsc_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [fmsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fmsc_pkg::GAIN_W-1:0]          cfg_wdata
);

  // Rounded z0*K keeps all its integer bits; the product holds it times an error.
  localparam int ZK_W   = 49 - COEF_FRAC_BITS;
  localparam int PROD_W = ZK_W + fmsc_pkg::COEF_W;
  localparam logic signed [fmsc_pkg::ACC_W-1:0] HALF =
    fmsc_pkg::ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [fmsc_pkg::ACC_W-1:0] DRIVE_MAX =
    fmsc_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [fmsc_pkg::ACC_W-1:0] DRIVE_MIN =
    fmsc_pkg::ACC_W'(-64'sd2147483648);
  localparam logic [fmsc_pkg::MOT_W-1:0] LAST_MOT =
    fmsc_pkg::MOT_W'(MOTOR_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_ZK = 5'b00010,
    ST_MUL_KE = 5'b00100,
    ST_MUL_ZE = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [fmsc_pkg::MOT_W-1:0] mot_r;

  logic signed [fmsc_pkg::SPEED_W-1:0] sp_r    [fmsc_pkg::NMOT];
  logic        [fmsc_pkg::GAIN_W-1:0]  gain_r  [fmsc_pkg::NMOT];
  logic signed [fmsc_pkg::SPEED_W-1:0] speed_r [fmsc_pkg::NMOT];
  logic signed [fmsc_pkg::SPEED_W-1:0] ep_r    [fmsc_pkg::NMOT];
  logic signed [fmsc_pkg::SPEED_W-1:0] ep2_r   [fmsc_pkg::NMOT];
  logic signed [fmsc_pkg::DRIVE_W-1:0] dp_r    [fmsc_pkg::NMOT];
  logic signed [fmsc_pkg::DRIVE_W-1:0] dp2_r   [fmsc_pkg::NMOT];

  logic signed [PROD_W-1:0]            prod_r;
  logic signed [ZK_W-1:0]              zk_r;
  logic signed [fmsc_pkg::ACC_W-1:0]   acc_r;
  logic signed [fmsc_pkg::SPEED_W-1:0] err_r;
  logic                                out_valid_r;
  fmsc_pkg::out_beat_t                 out_r;

  logic signed [fmsc_pkg::COEF_W-1:0]  k_c, z0_c;
  logic signed [fmsc_pkg::SPEED_W:0]   diff_c;
  logic signed [fmsc_pkg::SPEED_W-1:0] err_c;
  logic signed [ZK_W-1:0]              mul_a_c;
  logic signed [fmsc_pkg::COEF_W-1:0]  mul_b_c;
  logic signed [PROD_W-1:0]            mul_p_c;
  logic signed [PROD_W-1:0]            zk_sum_c;
  logic signed [ZK_W-1:0]              zk_c;
  logic signed [fmsc_pkg::ACC_W-1:0]   dp_ext_c, dp2_ext_c, base_c;
  logic signed [fmsc_pkg::ACC_W-1:0]   fin_sum_c, fin_shift_c;
  logic signed [fmsc_pkg::DRIVE_W-1:0] drive_c;
  logic signed [fmsc_pkg::DRIVE_W-1:0] drive_sel_c [fmsc_pkg::NMOT];
  logic                                last_c, fin_go_c, accept_c;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept_c  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Coefficients of the motor in work.
  assign k_c  = gain_r[mot_r][fmsc_pkg::GAIN_W-1:fmsc_pkg::COEF_W];
  assign z0_c = gain_r[mot_r][fmsc_pkg::COEF_W-1:0];

  // New error, saturated to 24 bits.
  assign diff_c = {sp_r[mot_r][fmsc_pkg::SPEED_W-1], sp_r[mot_r]}
                - {speed_r[mot_r][fmsc_pkg::SPEED_W-1], speed_r[mot_r]};
  always_comb begin
    if (diff_c[fmsc_pkg::SPEED_W] != diff_c[fmsc_pkg::SPEED_W-1]) begin
      err_c = diff_c[fmsc_pkg::SPEED_W] ? {1'b1, {(fmsc_pkg::SPEED_W-1){1'b0}}}
                                        : {1'b0, {(fmsc_pkg::SPEED_W-1){1'b1}}};
    end else begin
      err_c = diff_c[fmsc_pkg::SPEED_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      ST_MUL_ZK: begin
        mul_a_c = ZK_W'(z0_c);
        mul_b_c = k_c;
      end
      ST_MUL_KE: begin
        mul_a_c = ZK_W'(k_c);
        mul_b_c = ep_r[mot_r];
      end
      ST_MUL_ZE: begin
        mul_a_c = zk_r;
        mul_b_c = ep2_r[mot_r];
      end
      default: begin
        mul_a_c = '0;
        mul_b_c = '0;
      end
    endcase
  end

  assign mul_p_c = PROD_W'(mul_a_c) * PROD_W'(mul_b_c);

  // z0*K rounded half up back to the coefficient scale.
  assign zk_sum_c = prod_r + PROD_W'(HALF);
  assign zk_c     = ZK_W'(zk_sum_c >>> COEF_FRAC_BITS);

  // Pole terms (3*drive_prev - drive_prev2) * 2^(F-1), with the rounding half folded in.
  assign dp_ext_c  = fmsc_pkg::ACC_W'(dp_r[mot_r]);
  assign dp2_ext_c = fmsc_pkg::ACC_W'(dp2_r[mot_r]);
  assign base_c    = (((dp_ext_c <<< 1) + dp_ext_c - dp2_ext_c) <<< (COEF_FRAC_BITS - 1))
                   + HALF;

  // Final term, scale back and saturate to 32 bits.
  assign fin_sum_c   = acc_r - fmsc_pkg::ACC_W'(prod_r);
  assign fin_shift_c = fin_sum_c >>> COEF_FRAC_BITS;
  always_comb begin
    if (fin_shift_c > DRIVE_MAX) begin
      drive_c = DRIVE_MAX[fmsc_pkg::DRIVE_W-1:0];
    end else if (fin_shift_c < DRIVE_MIN) begin
      drive_c = DRIVE_MIN[fmsc_pkg::DRIVE_W-1:0];
    end else begin
      drive_c = fin_shift_c[fmsc_pkg::DRIVE_W-1:0];
    end
  end

  // The last motor holds until the output register is free.
  assign last_c   = (mot_r == LAST_MOT);
  assign fin_go_c = !last_c || !out_valid_r || out_ready;

  // Result beat: drives already formed, with the one just finished.
  always_comb begin
    for (int m = 0; m < fmsc_pkg::NMOT; m++) begin
      drive_sel_c[m] = (fmsc_pkg::MOT_W'(m) == mot_r) ? drive_c : dp_r[m];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept_c) state_nxt = ST_MUL_ZK;
      ST_MUL_ZK: state_nxt = ST_MUL_KE;
      ST_MUL_KE: state_nxt = ST_MUL_ZE;
      ST_MUL_ZE: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go_c) state_nxt = last_c ? ST_IDLE : ST_MUL_ZK;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control state, registers and histories.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mot_r       <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < fmsc_pkg::NMOT; m++) begin
        sp_r[m]   <= '0;
        gain_r[m] <= '0;
        ep_r[m]   <= '0;
        ep2_r[m]  <= '0;
        dp_r[m]   <= '0;
        dp2_r[m]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Configuration writes; motors beyond the count are ignored.
      if (cfg_we) begin
        if (cfg_index < fmsc_pkg::CFG_GAIN_BASE) begin
          if (32'(cfg_index - fmsc_pkg::CFG_SETPOINT_BASE) < MOTOR_COUNT) begin
            sp_r[fmsc_pkg::MOT_W'(cfg_index - fmsc_pkg::CFG_SETPOINT_BASE)] <=
              cfg_wdata[fmsc_pkg::SPEED_W-1:0];
          end
        end else begin
          if (32'(cfg_index - fmsc_pkg::CFG_GAIN_BASE) < MOTOR_COUNT) begin
            gain_r[fmsc_pkg::MOT_W'(cfg_index - fmsc_pkg::CFG_GAIN_BASE)] <= cfg_wdata;
          end
        end
      end

      // Output valid flag: set by the last motor, cleared when the beat is taken.
      if ((state_r == ST_FIN) && fin_go_c && last_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (accept_c) begin
        mot_r <= '0;
      end

      if ((state_r == ST_FIN) && fin_go_c) begin
        ep2_r[mot_r] <= ep_r[mot_r];
        ep_r[mot_r]  <= err_r;
        dp2_r[mot_r] <= dp_r[mot_r];
        dp_r[mot_r]  <= drive_c;
        if (!last_c) begin
          mot_r <= mot_r + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept_c) begin
      speed_r[0] <= in_data.speed_m1;
      speed_r[1] <= in_data.speed_m2;
      speed_r[2] <= in_data.speed_m3;
      speed_r[3] <= in_data.speed_m4;
    end
    case (state_r)
      ST_MUL_ZK: begin
        prod_r <= mul_p_c;
        acc_r  <= base_c;
        err_r  <= err_c;
      end
      ST_MUL_KE: begin
        zk_r   <= zk_c;
        prod_r <= mul_p_c;
      end
      ST_MUL_ZE: begin
        acc_r  <= acc_r + fmsc_pkg::ACC_W'(prod_r);
        prod_r <= mul_p_c;
      end
      default: begin
      end
    endcase
    if ((state_r == ST_FIN) && fin_go_c && last_c) begin
      out_r.drive_m1 <= drive_sel_c[0];
      out_r.drive_m2 <= drive_sel_c[1];
      out_r.drive_m3 <= drive_sel_c[2];
      out_r.drive_m4 <= drive_sel_c[3];
    end
  end

endmodule

>>> design/fmsc_checker.sv
// Port-level checks of the four-motor speed compensator, bound to the top level.
`include "four_motor_speed_compensator_core_macros.svh"

module fmsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fmsc_pkg::out_beat_t out_data
);

  // A stalled result beat holds its value.
  `FMSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // The block is busy for the cycles after taking a beat.
  `FMSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A fresh result only appears at the end of a busy period.
  `FMSC_ASSERT_IMPL(a_result_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind four_motor_speed_compensator_core fmsc_checker u_fmsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/tb_four_motor_speed_compensator_core.sv
// Self-checking testbench for the four-motor speed compensator core.
module tb_four_motor_speed_compensator_core;
  import fmsc_pkg::*;

  localparam int ACTIVE_MOTORS = 4;
  localparam int COEF_FRAC = 22;

  localparam longint ERR_MAX = 64'sd8388607;
  localparam longint ERR_MIN = -64'sd8388608;
  localparam longint DRV_MAX = 64'sd2147483647;
  localparam longint DRV_MIN = -64'sd2147483648;

  localparam logic signed [SPEED_W-1:0] SPD_MAX = 24'sh7FFFFF;
  localparam logic signed [SPEED_W-1:0] SPD_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sh400000;
  localparam logic signed [COEF_W-1:0] COEF_HALF = 24'sh200000;

  // Clock and ports of the block; the inputs are known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  // Mirror of the registers and the per-motor histories.
  logic signed [SPEED_W-1:0] sp_reg [NMOT];
  logic [GAIN_W-1:0] gw_reg [NMOT];
  logic signed [SPEED_W-1:0] e_hist1 [NMOT];
  logic signed [SPEED_W-1:0] e_hist2 [NMOT];
  logic signed [DRIVE_W-1:0] d_hist1 [NMOT];
  logic signed [DRIVE_W-1:0] d_hist2 [NMOT];

  in_beat_t pending_ticks [$];
  out_beat_t expected_drives [$];
  int unsigned ticks_queued = 0;
  int unsigned drives_checked = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int unsigned hold_left = 0;

  four_motor_speed_compensator_core #(
    .MOTOR_COUNT(ACTIVE_MOTORS),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int m = 0; m < NMOT; m++) begin
      sp_reg[m] = '0;
      gw_reg[m] = '0;
      e_hist1[m] = '0;
      e_hist2[m] = '0;
      d_hist1[m] = '0;
      d_hist2[m] = '0;
    end
  end

  // Works out the four drives of one control tick and advances the histories.
  function automatic out_beat_t next_drives(in_beat_t b);
    logic signed [SPEED_W-1:0] spd [NMOT];
    logic signed [DRIVE_W-1:0] dsat [NMOT];
    out_beat_t r;
    longint half, err, kk, zz, zk, acc, d;
    int m;
    half = longint'(1) << (COEF_FRAC - 1);
    spd[0] = b.speed_m1;
    spd[1] = b.speed_m2;
    spd[2] = b.speed_m3;
    spd[3] = b.speed_m4;
    for (m = 0; m < NMOT; m++) begin
      if (m >= ACTIVE_MOTORS) begin
        dsat[m] = '0;
      end else begin
        err = longint'(sp_reg[m]) - longint'(spd[m]);
        if (err > ERR_MAX) err = ERR_MAX;
        else if (err < ERR_MIN) err = ERR_MIN;
        kk = longint'($signed(gw_reg[m][47:24]));
        zz = longint'($signed(gw_reg[m][23:0]));
        // Zero times gain, rounded half up back to the coefficient format.
        zk = (zz * kk + half) >>> COEF_FRAC;
        acc = (3 * longint'(d_hist1[m]) - longint'(d_hist2[m])) * half
            + kk * longint'(e_hist1[m]) - zk * longint'(e_hist2[m]);
        d = (acc + half) >>> COEF_FRAC;
        if (d > DRV_MAX) d = DRV_MAX;
        else if (d < DRV_MIN) d = DRV_MIN;
        dsat[m] = d[DRIVE_W-1:0];
        e_hist2[m] = e_hist1[m];
        e_hist1[m] = err[SPEED_W-1:0];
        d_hist2[m] = d_hist1[m];
        d_hist1[m] = dsat[m];
      end
    end
    r.drive_m1 = dsat[0];
    r.drive_m2 = dsat[1];
    r.drive_m3 = dsat[2];
    r.drive_m4 = dsat[3];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_drive(int m, logic signed [DRIVE_W-1:0] want,
                             logic signed [DRIVE_W-1:0] got);
    if (want !== got) report_mismatch($sformatf("drive of motor %0d", m), want, got);
  endtask

  // Input side: offers queued ticks, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_drives.push_back(next_drives(in_data));
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output side: compares each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("drive beat with no tick outstanding", 0, 0);
        end else begin
          want = expected_drives.pop_front();
          check_drive(1, want.drive_m1, out_data.drive_m1);
          check_drive(2, want.drive_m2, out_data.drive_m2);
          check_drive(3, want.drive_m3, out_data.drive_m3);
          check_drive(4, want.drive_m4, out_data.drive_m4);
          drives_checked++;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [SPEED_W-1:0] rnd24();
    logic [31:0] raw;
    raw = $urandom;
    return raw[SPEED_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] rnd48();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[GAIN_W-1:0];
  endfunction

  // One register write; the mirror follows at the edge that takes it.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < CFG_GAIN_BASE) sp_reg[2'(idx - CFG_SETPOINT_BASE)] = data[SPEED_W-1:0];
    else gw_reg[2'(idx - CFG_GAIN_BASE)] = data;
  endtask

  task automatic write_all(logic [SPEED_W-1:0] s1, s2, s3, s4,
                           logic [GAIN_W-1:0] g1, g2, g3, g4);
    cfg_write(CFG_SETPOINT_BASE + 3'd0, {24'd0, s1});
    cfg_write(CFG_SETPOINT_BASE + 3'd1, {24'd0, s2});
    cfg_write(CFG_SETPOINT_BASE + 3'd2, {24'd0, s3});
    cfg_write(CFG_SETPOINT_BASE + 3'd3, {24'd0, s4});
    cfg_write(CFG_GAIN_BASE + 3'd0, g1);
    cfg_write(CFG_GAIN_BASE + 3'd1, g2);
    cfg_write(CFG_GAIN_BASE + 3'd2, g3);
    cfg_write(CFG_GAIN_BASE + 3'd3, g4);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_tick(in_beat_t b);
    pending_ticks.push_back(b);
    ticks_queued++;
  endtask

  // Random ticks: mostly speeds close to the setpoint, some anywhere, and
  // runs of full-scale speeds that flip direction every forty ticks so
  // that the drives are driven into saturation.
  task automatic queue_ticks(int count, int unsigned extreme_pct);
    logic signed [SPEED_W-1:0] spd [NMOT];
    int unsigned sel;
    int noise;
    bit push_hi;
    for (int i = 0; i < count; i++) begin
      push_hi = ((i / 40) % 2) == 1;
      for (int m = 0; m < NMOT; m++) begin
        sel = $urandom_range(99);
        noise = int'($urandom_range(8191)) - 4096;
        if (sel < extreme_pct) spd[m] = (push_hi ^ m[0]) ? SPD_MAX : SPD_MIN;
        else if (sel < extreme_pct + 30) spd[m] = rnd24();
        else spd[m] = sp_reg[m] + noise[SPEED_W-1:0];
      end
      queue_tick(in_beat_t'{spd[0], spd[1], spd[2], spd[3]});
    end
  endtask

  // Idle once every queued tick has come back as a checked drive beat.
  task automatic wait_idle();
    while (drives_checked != ticks_queued) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, error overflow and drive saturation.
    write_all(SPD_MAX, SPD_MIN, '0, SPD_MAX,
              {COEF_MAX, COEF_MIN}, {COEF_MIN, COEF_MIN},
              {COEF_ONE, COEF_HALF}, {COEF_MIN, COEF_MAX});
    queue_tick(in_beat_t'{24'sd0, 24'sd0, 24'sd0, 24'sd0});
    queue_tick(in_beat_t'{SPD_MIN, SPD_MIN, SPD_MIN, SPD_MIN});
    queue_tick(in_beat_t'{SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX});
    queue_tick(in_beat_t'{-24'sd1, -24'sd1, -24'sd1, -24'sd1});
    queue_tick(in_beat_t'{24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA});
    for (int i = 0; i < 20; i++) queue_tick(in_beat_t'{SPD_MIN, SPD_MAX, SPD_MIN, SPD_MAX});
    wait_idle();

    // Realistic gains, no idling on either side (gains approximate Q2.22).
    write_all(rnd24() >>> 3, rnd24() >>> 3, rnd24() >>> 3, rnd24() >>> 3,
              {24'sd225773, 24'sd3050349}, {24'sd193181, 24'sd2802471},
              {24'sd230982, 24'sd3058032}, {24'sd192431, 24'sd2848750});
    queue_ticks(160, 5);
    wait_idle();

    // Random registers, sender idle half the time.
    send_idle_pct = 50;
    write_all(rnd24(), rnd24(), rnd24(), rnd24(), rnd48(), rnd48(), rnd48(), rnd48());
    queue_ticks(160, 10);
    wait_idle();

    // Extreme registers, receiver stalling half the time, plus a long
    // hold-off so that the block fills up and stops taking beats.
    send_idle_pct = 0;
    recv_stall_pct = 50;
    write_all(SPD_MIN, SPD_MAX, SPD_MAX, SPD_MIN,
              {COEF_MIN, COEF_MAX}, {COEF_MAX, COEF_MAX},
              {COEF_MAX, COEF_MIN}, {COEF_MIN, COEF_MIN});
    queue_ticks(160, 40);
    while (pending_ticks.size() > 140) @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_idle();

    // Mixed registers with zero gain, light idling on both sides.
    send_idle_pct = 14;
    recv_stall_pct = 14;
    write_all('0, rnd24(), rnd24() >>> 4, SPD_MAX,
              '0, {COEF_ONE, 24'sd0}, rnd48(), {COEF_MAX, COEF_MAX});
    queue_ticks(150, 15);
    wait_idle();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
